/* design/lgge_pkg.sv */
// ----------------------------------------------------------------------------
// Life grid generation engine package
// Shared request codes, register indexes, sizes and the B3/S23 cell rule.
// ----------------------------------------------------------------------------
package lgge_pkg;

  // Configuration register widths and reset size.
  localparam int unsigned CFG_W   = 7;
  localparam logic [6:0]  DIM_RST = 7'd64;

  // Request field widths.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned COORD_W = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_index_t;

  // Neighbor counts that matter for the rule.
  localparam logic [3:0] NB_KEEP = 4'd2;
  localparam logic [3:0] NB_BORN = 4'd3;

  // Next state of one cell from its eight neighbor bits and its own value.
  function automatic logic lgge_rule(input logic [7:0] nb, input logic self_bit);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 0; k < 8; k++) begin
      cnt = cnt + {3'b000, nb[k]};
    end
    return (cnt == NB_BORN) || ((cnt == NB_KEEP) && self_bit);
  endfunction

endpackage

/* design/lgge_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lgge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/lgge_row_calc.sv */
// ----------------------------------------------------------------------------
// Life row update
// Computes one new row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module lgge_row_calc
  import lgge_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  logic [MAX_COLS-1:0] up_i,
  input  logic [MAX_COLS-1:0] mid_i,
  input  logic [MAX_COLS-1:0] dn_i,
  input  logic [MAX_COLS-1:0] col_mask_i,
  input  logic                row_act_i,
  output logic [MAX_COLS-1:0] row_o
);

  logic [MAX_COLS-1:0] up_m, mid_m, dn_m;
  logic [MAX_COLS-1:0] up_l, up_h, mid_l, mid_h, dn_l, dn_h;

  // Columns outside the grid count as dead neighbors.
  assign up_m  = up_i & col_mask_i;
  assign mid_m = mid_i & col_mask_i;
  assign dn_m  = dn_i & col_mask_i;

  // Bit c of *_l holds column c-1, bit c of *_h holds column c+1.
  assign up_l  = up_m << 1;
  assign up_h  = up_m >> 1;
  assign mid_l = mid_m << 1;
  assign mid_h = mid_m >> 1;
  assign dn_l  = dn_m << 1;
  assign dn_h  = dn_m >> 1;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (row_act_i && col_mask_i[c]) begin
        row_o[c] = lgge_rule({up_l[c], up_m[c], up_h[c], mid_l[c], mid_h[c],
                              dn_l[c], dn_m[c], dn_h[c]}, mid_i[c]);
      end else begin
        row_o[c] = mid_i[c];
      end
    end
  end

endmodule

/* design/life_grid_generation_engine_unit.sv */
// ----------------------------------------------------------------------------
// Life grid generation engine
// Bounded Conway Life grid (B3/S23) held as rows in a double-buffered RAM.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel writes one cell, reads one cell or
// advances the whole grid by one generation; every request produces exactly
// one result on the out_ channel. A read returns the cell in out_cell_value.
// A read or write whose coordinate lies outside the configured grid is
// ignored and reports out_status = 1. Request type 3 is ignored silently.
// Sequence: a cell read or write reads its row in the cycle it is accepted;
// a read then takes the cell from that row, and a write modifies the row and
// writes it back, before the result is posted. A flagged coordinate or request
// type 3 posts its result without a row access. An advance reads one grid row
// per cycle from the current bank and writes the new row to the other bank,
// sweeping all MAX_ROWS rows before the banks swap and its result is posted.
// One request is in work at a time and the next is taken once the result is posted.
// Reset: after rst_n the block runs a clearing pass of MAX_ROWS cycles over
// bank zero with in_ready low; configuration writes are taken meanwhile.
// Stalls: the result sits in an output register; a new request is accepted
// while it waits, and a later result waits in the engine until out_ready
// frees the output register.
// Configuration: cfg_we writes cfg_data to grid_width (index 0) or
// grid_height (index 1); values above MAX_COLS/MAX_ROWS are capped.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit
  import lgge_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // Request channel
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_req_type,
  input  logic [5:0]   in_cell_row,
  input  logic [5:0]   in_cell_col,
  input  logic         in_write_value,
  // Result channel
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_cell_value,
  output logic         out_status,
  // Configuration port
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data
);

  // Row address bits, column index bits and counters able to hold the size.
  localparam int RIDX_W    = $clog2(MAX_ROWS);
  localparam int CIDX_W    = $clog2(MAX_COLS);
  localparam int SCNT_W    = $clog2(MAX_ROWS + 1);
  localparam int EW_W      = $clog2(MAX_COLS + 1);
  localparam int RAM_AW    = RIDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ACCESS = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_SWAP   = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  // Control state
  state_t            state_r, state_nxt;
  logic [6:0]        grid_width_r, grid_width_nxt;
  logic [6:0]        grid_height_r, grid_height_nxt;
  logic              buf_r, buf_nxt;
  logic [RIDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SCNT_W-1:0] sw_cnt_r, sw_cnt_nxt;
  logic              sw_dv_r, sw_dv_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  logic [SCNT_W-1:0]   sw_tag_r, sw_tag_nxt;
  logic [MAX_COLS-1:0] up_r, up_nxt;
  logic [MAX_COLS-1:0] mid_r, mid_nxt;
  req_type_t           req_r, req_nxt;
  logic [RIDX_W-1:0]   row_r, row_nxt;
  logic [CIDX_W-1:0]   col_r, col_nxt;
  logic                val_r, val_nxt;
  logic                res_value_r, res_value_nxt;
  logic                res_status_r, res_status_nxt;
  logic                out_cell_value_r, out_cell_value_nxt;
  logic                out_status_r, out_status_nxt;

  // RAM ports
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  // Sweep datapath
  logic [EW_W-1:0]     eff_w;
  logic [SCNT_W-1:0]   eff_h;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] dn_row, new_row, mod_row;
  logic [SCNT_W-1:0]   sw_row;
  logic                row_act;
  logic                in_oob;
  logic                in_fire;
  req_type_t           in_req;

  // Effective grid size: register value capped at the storage size.
  assign eff_w = (int'(grid_width_r) > MAX_COLS) ? EW_W'(MAX_COLS) : EW_W'(grid_width_r);
  assign eff_h = (int'(grid_height_r) > MAX_ROWS) ? SCNT_W'(MAX_ROWS)
                                                  : SCNT_W'(grid_height_r);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(eff_w));
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_req   = req_type_t'(in_req_type);
  assign in_oob   = (int'(in_cell_row) >= int'(eff_h)) || (int'(in_cell_col) >= int'(eff_w));

  // The sweep tag names the row whose data arrives this cycle; the row
  // written back is the one before it, using the arriving row as its lower
  // neighbor. Rows at or past the grid height read as dead neighbors.
  assign sw_row  = sw_tag_r - SCNT_W'(1);
  assign row_act = (sw_row < eff_h);
  assign dn_row  = (sw_tag_r < eff_h) ? ram_rdata : '0;

  lgge_row_calc #(
    .MAX_COLS (MAX_COLS)
  ) u_row_calc (
    .up_i       (up_r),
    .mid_i      (mid_r),
    .dn_i       (dn_row),
    .col_mask_i (col_mask),
    .row_act_i  (row_act),
    .row_o      (new_row)
  );

  // Row with the addressed cell replaced, for a cell write.
  always_comb begin
    mod_row         = ram_rdata;
    mod_row[col_r]  = val_r;
  end

  // Read address: the sweep row during the sweep, the request row otherwise.
  always_comb begin
    if (state_r == ST_SWEEP) begin
      ram_raddr = {buf_r, sw_cnt_r[RIDX_W-1:0]};
    end else begin
      ram_raddr = {buf_r, RIDX_W'(in_cell_row)};
    end
  end

  // Write port: clearing pass, cell write-back or new generation row.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {1'b0, clr_cnt_r};
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if ((state_r == ST_ACCESS) && (req_r == REQ_WRITE)) begin
      ram_we    = 1'b1;
      ram_waddr = {buf_r, row_r};
      ram_wdata = mod_row;
    end else if (sw_dv_r && (sw_tag_r != '0)) begin
      ram_we    = 1'b1;
      ram_waddr = {~buf_r, sw_row[RIDX_W-1:0]};
      ram_wdata = new_row;
    end
  end

  lgge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt          = state_r;
    grid_width_nxt     = grid_width_r;
    grid_height_nxt    = grid_height_r;
    buf_nxt            = buf_r;
    clr_cnt_nxt        = clr_cnt_r;
    sw_cnt_nxt         = sw_cnt_r;
    sw_dv_nxt          = (state_r == ST_SWEEP);
    sw_tag_nxt         = sw_cnt_r;
    up_nxt             = up_r;
    mid_nxt            = mid_r;
    req_nxt            = req_r;
    row_nxt            = row_r;
    col_nxt            = col_r;
    val_nxt            = val_r;
    res_value_nxt      = res_value_r;
    res_status_nxt     = res_status_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_cell_value_nxt = out_cell_value_r;
    out_status_nxt     = out_status_r;

    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_nxt  = cfg_data;
        CFG_GRID_HEIGHT: grid_height_nxt = cfg_data;
        default:         grid_width_nxt  = grid_width_r;
      endcase
    end

    // Sliding three-row window over the old grid.
    if (sw_dv_r) begin
      up_nxt  = (sw_tag_r == '0) ? '0 : mid_r;
      mid_nxt = ram_rdata;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + RIDX_W'(1);
        if (clr_cnt_r == RIDX_W'(MAX_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt        = in_req;
          row_nxt        = RIDX_W'(in_cell_row);
          col_nxt        = CIDX_W'(in_cell_col);
          val_nxt        = in_write_value;
          res_value_nxt  = 1'b0;
          res_status_nxt = 1'b0;
          case (in_req)
            REQ_WRITE, REQ_READ: begin
              if (in_oob) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_ACCESS;
              end
            end
            REQ_ADVANCE: begin
              sw_cnt_nxt = '0;
              state_nxt  = ST_SWEEP;
            end
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_ACCESS: begin
        if (req_r == REQ_READ) begin
          res_value_nxt = ram_rdata[col_r];
        end
        state_nxt = ST_RESP;
      end
      ST_SWEEP: begin
        sw_cnt_nxt = sw_cnt_r + SCNT_W'(1);
        if (sw_cnt_r == SCNT_W'(MAX_ROWS)) begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        // The last row is written this cycle; the new bank becomes current.
        buf_nxt   = ~buf_r;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_cell_value_nxt = res_value_r;
          out_status_nxt     = res_status_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      grid_width_r  <= DIM_RST;
      grid_height_r <= DIM_RST;
      buf_r         <= 1'b0;
      clr_cnt_r     <= '0;
      sw_cnt_r      <= '0;
      sw_dv_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      buf_r         <= buf_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      sw_cnt_r      <= sw_cnt_nxt;
      sw_dv_r       <= sw_dv_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_tag_r         <= sw_tag_nxt;
    up_r             <= up_nxt;
    mid_r            <= mid_nxt;
    req_r            <= req_nxt;
    row_r            <= row_nxt;
    col_r            <= col_nxt;
    val_r            <= val_nxt;
    res_value_r      <= res_value_nxt;
    res_status_r     <= res_status_nxt;
    out_cell_value_r <= out_cell_value_nxt;
    out_status_r     <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_value_r;
  assign out_status     = out_status_r;

endmodule
